### sv/tlbp_pkg.sv
package tlbp_pkg;

    localparam int ADDR_W      = 32;
    localparam int COUNT_W     = 32;
    localparam int CFG_W       = 4;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 72;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int MOD_DIGIT_W = 4;
    localparam int MOD_STEPS   = ADDR_W / MOD_DIGIT_W;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

    localparam logic [0:0]       REG_COUNTER_BITS   = 1'b0;
    localparam logic [CFG_W-1:0] COUNTER_BITS_RESET = 4'd2;

    typedef struct packed {
        logic clear;
        logic accept;
        logic mod_step;
        logic ctr_rd;
        logic out_load;
    } tlbp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic mod_bypass;
        logic mod_done;
        logic out_valid;
    } tlbp_status_t;

endpackage

### sv/tlbp_ctrl.sv
module tlbp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   m_tready,
    input  tlbp_pkg::tlbp_status_t status,
    output tlbp_pkg::tlbp_cmd_t    cmd
);
    import tlbp_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_MOD   = 5'b00100,
        ST_HIST  = 5'b01000,
        ST_CTR   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_free;
    logic   accept;

    assign out_free = !status.out_valid || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_CTR) && out_free);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.accept   = accept;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = status.mod_bypass ? ST_HIST : ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_done)
                begin
                    state_next = ST_HIST;
                end
            end
            ST_HIST:
            begin
                cmd.ctr_rd = 1'b1;
                state_next = ST_CTR;
            end
            ST_CTR:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (accept)
                    begin
                        state_next = status.mod_bypass ? ST_HIST : ST_MOD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/tlbp_datapath.sv
module tlbp_datapath #(
    parameter int HISTORY_ENTRIES  = 128,
    parameter int HISTORY_BITS     = 10,
    parameter int MAX_COUNTER_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlbp_pkg::tlbp_cmd_t           cmd,
    output tlbp_pkg::tlbp_status_t        status,
    input  logic [tlbp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          cfg_we,
    input  logic [tlbp_pkg::CFG_W-1:0]    cfg_wdata,
    output logic [tlbp_pkg::CFG_W-1:0]    counter_bits,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tlbp_pkg::M_TDATA_W-1:0] m_tdata
);
    import tlbp_pkg::*;

    localparam int  SW       = $clog2(HISTORY_ENTRIES);
    localparam int  HB       = HISTORY_BITS;
    localparam int  MB       = MAX_COUNTER_BITS;
    localparam int  PE       = 1 << HISTORY_BITS;
    localparam int  CLR_N    = (HISTORY_ENTRIES > PE) ? HISTORY_ENTRIES : PE;
    localparam int  CW       = $clog2(CLR_N);
    localparam int  WW       = $clog2(MAX_COUNTER_BITS + 1);
    localparam bit  POW2     = (HISTORY_ENTRIES & (HISTORY_ENTRIES - 1)) == 0;

    logic [HB-1:0]    hist_mem [HISTORY_ENTRIES];
    logic [MB-1:0]    ctr_mem  [PE];

    logic [CFG_W-1:0] counter_bits_reg;
    logic [CW-1:0]    clr_reg;
    logic [SW-1:0]    slot_reg;
    logic             taken_reg;
    logic [HB-1:0]    hist_rdata_reg;
    logic [HB-1:0]    hist_idx_reg;
    logic [MB-1:0]    ctr_rdata_reg;
    logic [COUNT_W-1:0] branch_count_reg;
    logic [COUNT_W-1:0] miss_count_reg;
    logic             m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic             hist_rd_en;
    logic [SW-1:0]    hist_rd_addr;
    logic [WW-1:0]    width;
    logic [MB-1:0]    top_val;
    logic [MB-1:0]    half_val;
    logic             guess;
    logic             miss;
    logic [MB-1:0]    ctr_new;
    logic [COUNT_W-1:0] branch_count_next;
    logic [COUNT_W-1:0] miss_count_next;

    assign counter_bits      = counter_bits_reg;
    assign status.clear_done = (clr_reg == CW'(CLR_N - 1));
    assign status.mod_bypass = POW2;
    assign status.out_valid  = m_tvalid_reg;
    assign m_tvalid          = m_tvalid_reg;
    assign m_tdata           = m_tdata_reg;

    generate
        if (POW2)
        begin : g_mask
            assign status.mod_done = 1'b1;
            assign hist_rd_en      = cmd.accept;
            assign hist_rd_addr    = s_tdata[SW-1:0];
        end
        else
        begin : g_rem
            logic [ADDR_W-1:0]    addr_sh_reg;
            logic [SW-1:0]        rem_reg;
            logic [MOD_CNT_W-1:0] cnt_reg;
            logic [SW:0]          rem_work;

            always_comb
            begin
                rem_work = {1'b0, rem_reg};
                for (int i = 0; i < MOD_DIGIT_W; i++)
                begin
                    rem_work = {rem_work[SW-1:0], addr_sh_reg[ADDR_W-1-i]};
                    if (rem_work >= (SW+1)'(HISTORY_ENTRIES))
                    begin
                        rem_work = rem_work - (SW+1)'(HISTORY_ENTRIES);
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (cmd.accept)
                begin
                    addr_sh_reg <= s_tdata[ADDR_W-1:0];
                    rem_reg     <= '0;
                    cnt_reg     <= '0;
                end
                else if (cmd.mod_step)
                begin
                    addr_sh_reg <= addr_sh_reg << MOD_DIGIT_W;
                    rem_reg     <= rem_work[SW-1:0];
                    cnt_reg     <= cnt_reg + 1'b1;
                end
            end

            assign status.mod_done = (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1));
            assign hist_rd_en      = cmd.mod_step && status.mod_done;
            assign hist_rd_addr    = rem_work[SW-1:0];
        end
    endgenerate

    // effective counter width, clamped to 1..MAX_COUNTER_BITS
    always_comb
    begin
        if (counter_bits_reg == '0)
        begin
            width = WW'(1);
        end
        else if (int'(counter_bits_reg) > MAX_COUNTER_BITS)
        begin
            width = WW'(MAX_COUNTER_BITS);
        end
        else
        begin
            width = WW'(counter_bits_reg);
        end
    end

    assign top_val  = {MB{1'b1}} >> (MB - int'(width));
    assign half_val = MB'(1) << (int'(width) - 1);
    assign guess    = (ctr_rdata_reg >= half_val);
    assign miss     = guess ^ taken_reg;

    always_comb
    begin
        if (taken_reg)
        begin
            ctr_new = (ctr_rdata_reg < top_val) ? ctr_rdata_reg + 1'b1 : top_val;
        end
        else
        begin
            ctr_new = (ctr_rdata_reg != '0) ? ctr_rdata_reg - 1'b1 : ctr_rdata_reg;
        end
    end

    assign branch_count_next = branch_count_reg + 1'b1;
    assign miss_count_next   = miss ? miss_count_reg + 1'b1 : miss_count_reg;

    // history table: clear sweep, read per item, write back shifted history
    always_ff @(posedge clk)
    begin
        if (cmd.clear && (int'(clr_reg) < HISTORY_ENTRIES))
        begin
            hist_mem[clr_reg[SW-1:0]] <= '0;
        end
        else if (cmd.ctr_rd)
        begin
            hist_mem[slot_reg] <= HB'({hist_rdata_reg, taken_reg});
        end
        if (hist_rd_en)
        begin
            hist_rdata_reg <= hist_mem[hist_rd_addr];
        end
    end

    // pattern counter table
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            ctr_mem[clr_reg[HB-1:0]] <= '0;
        end
        else if (cmd.out_load)
        begin
            ctr_mem[hist_idx_reg] <= ctr_new;
        end
        if (cmd.ctr_rd)
        begin
            ctr_rdata_reg <= ctr_mem[hist_rdata_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_rd_en)
        begin
            slot_reg <= hist_rd_addr;
        end
        if (cmd.accept)
        begin
            taken_reg <= s_tdata[ADDR_W];
        end
        if (cmd.ctr_rd)
        begin
            hist_idx_reg <= hist_rdata_reg;
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {6'b0, miss_count_next, branch_count_next, miss, guess};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_bits_reg <= COUNTER_BITS_RESET;
            clr_reg          <= '0;
            branch_count_reg <= '0;
            miss_count_reg   <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                counter_bits_reg <= cfg_wdata;
            end
            if (cmd.clear && !status.clear_done)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                branch_count_reg <= branch_count_next;
                miss_count_reg   <= miss_count_next;
                m_tvalid_reg     <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

### sv/two_level_local_branch_predictor_unit.sv
// two-level local (per-address history, global pattern table) branch predictor
// s_* channel: one beat per resolved branch, address plus actual outcome
// m_* channel: one beat per branch, prediction, miss flag and running counts
// apb port: register 0 (byte address 0) is the counter width in use, reset 2
// path: with HISTORY_ENTRIES a power of two the history is read as the beat is taken,
//   else in the last of 8 4-bit remainder steps; then the counter read and output load
// a new branch waits for the previous one's output load, as set by the dependent
//   history read, then counter read and write-back
// reset: clears both tables in a sweep of max(HISTORY_ENTRIES, 2**HISTORY_BITS)
//   addresses (1024 by default), s_tready stays low until the sweep ends
// receiver stall: the finished beat waits in the output register; one more
//   branch is taken in and held after its counter read until the output frees
module two_level_local_branch_predictor_unit #(
    parameter int HISTORY_ENTRIES  = 128,
    parameter int HISTORY_BITS     = 10,
    parameter int MAX_COUNTER_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // branch_address[31:0], taken[32], zero pad
    input  logic [tlbp_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // predicted_taken[0], mispredicted[1], branch_count[33:2],
    // mispredict_count[65:34], zero pad
    output logic [tlbp_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tlbp_pkg::PADDR_W-1:0]    paddr,
    input  logic [tlbp_pkg::PDATA_W-1:0]    pwdata,
    output logic [tlbp_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import tlbp_pkg::*;

    tlbp_cmd_t        cmd;
    tlbp_status_t     status;
    logic             cfg_we;
    logic [CFG_W-1:0] counter_bits;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1] == REG_COUNTER_BITS);
    assign prdata = (paddr[PADDR_W-1] == REG_COUNTER_BITS)
                    ? PDATA_W'(counter_bits) : '0;

    tlbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tlbp_datapath #(
        .HISTORY_ENTRIES  (HISTORY_ENTRIES),
        .HISTORY_BITS     (HISTORY_BITS),
        .MAX_COUNTER_BITS (MAX_COUNTER_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .s_tdata      (s_tdata),
        .cfg_we       (cfg_we),
        .cfg_wdata    (pwdata[CFG_W-1:0]),
        .counter_bits (counter_bits),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule
